### hdl/premultiplied_rgba_blend_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the premultiplied RGBA blend unit
// Short forms for same-cycle and next-cycle implication checks.
// ---------------------------------------------------------------------------
`ifndef PREMULTIPLIED_RGBA_BLEND_UNIT_DEFINES_SVH
`define PREMULTIPLIED_RGBA_BLEND_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRBU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRBU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/prbu_pkg.sv
// ---------------------------------------------------------------------------
// Blend unit package
// Types, constants and Q1.15 helpers shared by the blend pipeline.
// ---------------------------------------------------------------------------
package prbu_pkg;

   localparam logic [15:0] Q_ONE  = 16'h8000;
   localparam logic [15:0] Q_HALF = 16'h4000;

   // Divider geometry: quotient bits kept, and bits resolved per stage.
   localparam int DIV_QBITS     = 18;
   localparam int DIV_STEP_BITS = 3;
   localparam int DIV_STAGES    = DIV_QBITS / DIV_STEP_BITS;
   localparam int NUM_W         = 31;

   typedef enum logic [3:0] {
      MODE_CLEAR, MODE_SRCOVER, MODE_DSTOVER, MODE_SRCIN, MODE_DSTIN,
      MODE_SRCOUT, MODE_DSTOUT, MODE_SRCATOP, MODE_DSTATOP, MODE_XOR,
      MODE_PLUS, MODE_MODULATE, MODE_MULTIPLY, MODE_SCREEN, MODE_BURN,
      MODE_DODGE
   } mode_type;

   typedef struct packed {
      logic [15:0]          s;
      logic [15:0]          d;
      logic [15:0]          p_sida;
      logic [15:0]          p_disa;
      logic [15:0]          p_sda;
      logic [15:0]          p_dsa;
      logic [15:0]          p_sd;
      logic [NUM_W-1:0]     num;
      logic [15:0]          den;
      logic [DIV_QBITS-1:0] q;
      logic                 ovf;
      logic [15:0]          fin;
      logic [15:0]          b;
   } chan_type;

   // Channel 3 is alpha; its s and d are the source and destination alphas.
   typedef struct packed {
      mode_type           mode;
      logic [15:0]        cov;
      chan_type [3:0]     ch;
   } pix_type;

   function automatic logic [15:0] sat_one(input logic [17:0] x);
      return (x > {2'b00, Q_ONE}) ? Q_ONE : x[15:0];
   endfunction

   function automatic logic [15:0] qmul(input logic [15:0] a, input logic [15:0] b);
      logic [31:0] p;
      p = {16'b0, a} * {16'b0, b} + {16'b0, Q_HALF};
      return p[30:15];
   endfunction

endpackage

### hdl/prbu_front.sv
// ---------------------------------------------------------------------------
// Blend front end
// Saturates the inputs, then forms every product and the divider operands.
// ---------------------------------------------------------------------------
module prbu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  prbu_pkg::pix_type in_pix,
   output logic              out_valid,
   input  logic              out_ready,
   output prbu_pkg::pix_type out_pix
);
   import prbu_pkg::*;

   logic    v1_ff, v2_ff, adv1, adv2;
   pix_type p1_ff, p1_in, p2_ff, p2_in;
   logic [15:0] sa, da, isa, ida, dn;
   logic [31:0] prod;

   assign adv2      = !v2_ff || out_ready;
   assign adv1      = !v1_ff || adv2;
   assign in_ready  = adv1;
   assign out_valid = v2_ff;
   assign out_pix   = p2_ff;

   always_comb begin
      p1_in     = in_pix;
      p1_in.cov = sat_one({2'b00, in_pix.cov});
      for (int k = 0; k < 4; k++) begin
         p1_in.ch[k].s = sat_one({2'b00, in_pix.ch[k].s});
         p1_in.ch[k].d = sat_one({2'b00, in_pix.ch[k].d});
      end
   end

   always_comb begin
      p2_in = p1_ff;
      sa    = p1_ff.ch[3].s;
      da    = p1_ff.ch[3].d;
      isa   = Q_ONE - sa;
      ida   = Q_ONE - da;
      dn    = '0;
      prod  = '0;
      for (int k = 0; k < 4; k++) begin
         p2_in.ch[k].p_sida = qmul(p1_ff.ch[k].s, ida);
         p2_in.ch[k].p_disa = qmul(p1_ff.ch[k].d, isa);
         p2_in.ch[k].p_sda  = qmul(p1_ff.ch[k].s, da);
         p2_in.ch[k].p_dsa  = qmul(p1_ff.ch[k].d, sa);
         p2_in.ch[k].p_sd   = qmul(p1_ff.ch[k].s, p1_ff.ch[k].d);
         if (p1_ff.mode == MODE_BURN) begin
            dn = (p1_ff.ch[k].d < da) ? (da - p1_ff.ch[k].d) : '0;
            prod = {16'b0, dn} * {16'b0, sa};
            p2_in.ch[k].den = p1_ff.ch[k].s;
         end else begin
            prod = {16'b0, p1_ff.ch[k].d} * {16'b0, sa};
            p2_in.ch[k].den = (p1_ff.ch[k].s < sa) ? (sa - p1_ff.ch[k].s) : '0;
         end
         p2_in.ch[k].num = prod[NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) p1_ff <= p1_in;
      if (adv2) p2_ff <= p2_in;
   end

endmodule

### hdl/prbu_divider.sv
// ---------------------------------------------------------------------------
// Blend quotient divider
// Pipelined restoring divider for the burn and dodge quotients.
// ---------------------------------------------------------------------------
module prbu_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  prbu_pkg::pix_type in_pix,
   output logic              out_valid,
   input  logic              out_ready,
   output prbu_pkg::pix_type out_pix
);
   import prbu_pkg::*;

   localparam int NS = DIV_STAGES + 1;

   logic    v_ff [NS];
   logic    adv  [NS];
   pix_type p_ff [NS];
   pix_type p_in [NS];

   assign in_ready  = adv[0];
   assign out_valid = v_ff[NS-1];
   assign out_pix   = p_ff[NS-1];

   // Stage 0 adds half the divisor for rounding and flags quotients that
   // cannot fit; a zero divisor also lands in the overflow case.
   always_comb begin
      p_in[0] = in_pix;
      for (int k = 0; k < 3; k++) begin
         p_in[0].ch[k].num = in_pix.ch[k].num + NUM_W'(in_pix.ch[k].den >> 1);
         p_in[0].ch[k].ovf = p_in[0].ch[k].num[NUM_W-1:DIV_QBITS]
                             >= in_pix.ch[k].den;
         p_in[0].ch[k].q   = '0;
      end
   end

   for (genvar j = 1; j < NS; j++) begin : g_step
      always_comb begin
         logic [NUM_W+2:0] trial;
         int               i;
         p_in[j] = p_ff[j-1];
         trial   = '0;
         i       = 0;
         for (int k = 0; k < 3; k++) begin
            for (int b = 0; b < DIV_STEP_BITS; b++) begin
               i = DIV_QBITS - 1 - (j - 1) * DIV_STEP_BITS - b;
               trial = (NUM_W+3)'(p_in[j].ch[k].den) << i;
               if ({3'b000, p_in[j].ch[k].num} >= trial) begin
                  p_in[j].ch[k].num = p_in[j].ch[k].num - trial[NUM_W-1:0];
                  p_in[j].ch[k].q[i] = 1'b1;
               end
            end
         end
      end
   end

   for (genvar j = 0; j < NS; j++) begin : g_stage
      if (j == NS - 1) begin : g_last
         assign adv[j] = !v_ff[j] || out_ready;
      end else begin : g_mid
         assign adv[j] = !v_ff[j] || adv[j+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (adv[j]) begin
            v_ff[j] <= (j == 0) ? in_valid : v_ff[(j == 0) ? 0 : j - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[j]) p_ff[j] <= p_in[j];
      end
   end

endmodule

### hdl/prbu_back.sv
// ---------------------------------------------------------------------------
// Blend back end
// Final quotient product, mode select with saturation, and coverage lerp.
// ---------------------------------------------------------------------------
module prbu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  prbu_pkg::pix_type in_pix,
   output logic              out_valid,
   input  logic              out_ready,
   output prbu_pkg::pix_type out_pix
);
   import prbu_pkg::*;

   logic    va_ff, vb_ff, vc_ff, adva, advb, advc;
   pix_type pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;

   assign advc      = !vc_ff || out_ready;
   assign advb      = !vb_ff || advc;
   assign adva      = !va_ff || advb;
   assign in_ready  = adva;
   assign out_valid = vc_ff;
   assign out_pix   = pc_ff;

   // Clamp the quotient to destination alpha and take the last product.
   always_comb begin
      logic [15:0] da, t;
      pa_in = in_pix;
      da    = in_pix.ch[3].d;
      t     = '0;
      for (int k = 0; k < 3; k++) begin
         if (in_pix.ch[k].ovf || in_pix.ch[k].q > {2'b00, da}) t = da;
         else t = in_pix.ch[k].q[15:0];
         pa_in.ch[k].fin = qmul(in_pix.ch[3].s,
                                (in_pix.mode == MODE_BURN) ? (da - t) : t);
      end
   end

   always_comb begin
      logic [17:0] s, d, r, sdsum;
      logic [15:0] sa, da;
      pb_in = pa_ff;
      sa    = pa_ff.ch[3].s;
      da    = pa_ff.ch[3].d;
      s     = '0;
      d     = '0;
      r     = '0;
      sdsum = '0;
      for (int k = 0; k < 4; k++) begin
         s     = {2'b00, pa_ff.ch[k].s};
         d     = {2'b00, pa_ff.ch[k].d};
         sdsum = s + d;
         case (pa_ff.mode)
            MODE_CLEAR:    r = '0;
            MODE_SRCOVER:  r = s + 18'(pa_ff.ch[k].p_disa);
            MODE_DSTOVER:  r = d + 18'(pa_ff.ch[k].p_sida);
            MODE_SRCIN:    r = 18'(pa_ff.ch[k].p_sda);
            MODE_DSTIN:    r = 18'(pa_ff.ch[k].p_dsa);
            MODE_SRCOUT:   r = 18'(pa_ff.ch[k].p_sida);
            MODE_DSTOUT:   r = 18'(pa_ff.ch[k].p_disa);
            MODE_SRCATOP:  r = 18'(pa_ff.ch[k].p_sda) + 18'(pa_ff.ch[k].p_disa);
            MODE_DSTATOP:  r = 18'(pa_ff.ch[k].p_dsa) + 18'(pa_ff.ch[k].p_sida);
            MODE_XOR:      r = 18'(pa_ff.ch[k].p_sida) + 18'(pa_ff.ch[k].p_disa);
            MODE_PLUS:     r = sdsum;
            MODE_MODULATE: r = 18'(pa_ff.ch[k].p_sd);
            MODE_MULTIPLY: r = 18'(pa_ff.ch[k].p_sida) + 18'(pa_ff.ch[k].p_disa)
                               + 18'(pa_ff.ch[k].p_sd);
            MODE_SCREEN:   r = (sdsum > 18'(pa_ff.ch[k].p_sd))
                               ? sdsum - 18'(pa_ff.ch[k].p_sd) : '0;
            MODE_BURN: begin
               if (k == 3) r = sdsum - 18'(pa_ff.ch[k].p_sd);
               else if (pa_ff.ch[k].d >= da) r = d + 18'(pa_ff.ch[k].p_sida);
               else if (pa_ff.ch[k].s == '0) r = 18'(pa_ff.ch[k].p_disa);
               else r = 18'(pa_ff.ch[k].fin) + 18'(pa_ff.ch[k].p_sida)
                        + 18'(pa_ff.ch[k].p_disa);
            end
            default: begin
               if (k == 3) r = sdsum - 18'(pa_ff.ch[k].p_sd);
               else if (pa_ff.ch[k].d == '0) r = 18'(pa_ff.ch[k].p_sida);
               else if (pa_ff.ch[k].s >= sa) r = s + 18'(pa_ff.ch[k].p_disa);
               else r = 18'(pa_ff.ch[k].fin) + 18'(pa_ff.ch[k].p_sida)
                        + 18'(pa_ff.ch[k].p_disa);
            end
         endcase
         pb_in.ch[k].b = sat_one(r);
      end
   end

   // Coverage lerp toward the destination, rounded and saturated.
   always_comb begin
      logic [31:0] acc;
      logic [15:0] icov;
      pc_in = pb_ff;
      icov  = Q_ONE - pb_ff.cov;
      acc   = '0;
      for (int k = 0; k < 4; k++) begin
         acc = {16'b0, pb_ff.ch[k].d} * {16'b0, icov}
             + {16'b0, pb_ff.ch[k].b} * {16'b0, pb_ff.cov}
             + {16'b0, Q_HALF};
         pc_in.ch[k].b = sat_one({1'b0, acc[31:15]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (adva) va_ff <= in_valid;
         if (advb) vb_ff <= va_ff;
         if (advc) vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adva) pa_ff <= pa_in;
      if (advb) pb_ff <= pb_in;
      if (advc) pc_ff <= pc_in;
   end

endmodule

### hdl/premultiplied_rgba_blend_unit.sv
// ---------------------------------------------------------------------------
// Premultiplied RGBA blend unit
// Porter-Duff and separable blend modes with a final coverage lerp.
// ---------------------------------------------------------------------------
// The unit takes one pixel request per clock while the response side does
// not stall, and returns one blended pixel for each, in order. A request
// passes the two front stages (input saturation, products), one rounding
// stage ahead of the divider, the burn and dodge divider, which resolves
// three quotient bits per stage over six stages, and three back stages
// (quotient product, mode select, coverage lerp). Every stage has its own
// valid bit and advances whenever the stage after it can take data, so a
// stalled response only stops the pipeline once it has filled up. All
// channels are unsigned Q1.15 with 32768 meaning one; inputs above one are
// clamped first. The blend mode register resets to source-over and should
// be written only while no request is in flight.
module premultiplied_rgba_blend_unit (
   input  logic         clock,
   input  logic         reset,
   // Request: src_red, src_green, src_blue, src_alpha, dst_red, dst_green,
   // dst_blue, dst_alpha, coverage; 16 bits each, from the lowest bit up.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,
   // Response: out_red, out_green, out_blue, out_alpha; 16 bits each.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,
   // Blend mode register.
   input  logic         csr_wen,
   input  logic [3:0]   csr_wdata
);
   import prbu_pkg::*;

   mode_type mode_ff;
   pix_type  req_pix, front_pix, div_pix, out_pix;
   logic     front_valid, front_ready, div_valid, div_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SRCOVER;
      end else if (csr_wen) begin
         mode_ff <= mode_type'(csr_wdata);
      end
   end

   // Unpack the request; the mode rides along with each pixel.
   always_comb begin
      req_pix      = '0;
      req_pix.mode = mode_ff;
      req_pix.cov  = req_tdata[143:128];
      for (int k = 0; k < 4; k++) begin
         req_pix.ch[k].s = req_tdata[16*k +: 16];
         req_pix.ch[k].d = req_tdata[64 + 16*k +: 16];
      end
   end

   prbu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pix    (req_pix),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_pix   (front_pix)
   );

   prbu_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_pix    (front_pix),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_pix   (div_pix)
   );

   prbu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_pix    (div_pix),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pix   (out_pix)
   );

   // The back end leaves each finished channel in its blend field.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rsp_tdata[16*k +: 16] = out_pix.ch[k].b;
      end
   end

endmodule

### hdl/prbu_checker.sv
// ---------------------------------------------------------------------------
// Blend unit port checker
// Checks reset, flow control and output range at the top-level ports.
// ---------------------------------------------------------------------------
`include "premultiplied_rgba_blend_unit_defines.svh"

module prbu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // Nothing comes out right after reset.
   `PRBU_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "response valid after reset")

   // A stalled response holds its data.
   `PRBU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // With the output empty the whole pipeline can move, so requests are taken.
   `PRBU_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready, "request refused with empty output")

   // Every channel is saturated to one.
   `PRBU_ASSERT_NOW(a_rsp_range, clock, reset, rsp_tvalid, (rsp_tdata[15:0] <= 16'h8000) && (rsp_tdata[31:16] <= 16'h8000) && (rsp_tdata[47:32] <= 16'h8000) && (rsp_tdata[63:48] <= 16'h8000), "response channel above one")

endmodule

bind premultiplied_rgba_blend_unit prbu_checker u_prbu_checker (.*);
